>>> src/cmpc_pkg.sv
// Shared types, constants and codes for the coded-mask pixel colormap unit.
package cmpc_pkg;

  // Intensity format and palette geometry
  localparam int FRAC_BITS       = 8;
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_IDX_W       = $clog2(PALETTE_ENTRIES);
  localparam int RGB_W           = 24;
  localparam int LOG_SQUARINGS   = 16;
  localparam int LIN_SHIFT       = FRAC_BITS + 24;
  localparam int LOG_SHIFT       = 40;
  localparam logic [PAL_IDX_W-1:0] INDEX_MAX = PAL_IDX_W'(PALETTE_ENTRIES - 1);

  // Fixed-point one and the coded mask values
  localparam logic signed [31:0] INT_ONE      = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] CODE_POLYGON = -(32'sd4 <<< FRAC_BITS);
  localparam logic signed [31:0] CODE_UNDER   = -(32'sd3 <<< FRAC_BITS);
  localparam logic signed [31:0] CODE_OVER    = -(32'sd2 <<< FRAC_BITS);

  // mode_bits positions
  localparam int MODE_LOG   = 0;
  localparam int MODE_POLY  = 1;
  localparam int MODE_UNDER = 2;
  localparam int MODE_OVER  = 3;

  // Register indexes
  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_POLYGON     = 3'd1;
  localparam logic [2:0] REG_UNDER       = 3'd2;
  localparam logic [2:0] REG_OVER        = 3'd3;
  localparam logic [2:0] REG_LOWER_LEVEL = 3'd4;
  localparam logic [2:0] REG_LINEAR_GAIN = 3'd5;
  localparam logic [2:0] REG_LOG_LOWER   = 3'd6;
  localparam logic [2:0] REG_LOG_GAIN    = 3'd7;

  // Input action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  // color_source codes
  localparam logic [1:0] SRC_PALETTE = 2'd0;
  localparam logic [1:0] SRC_POLYGON = 2'd1;
  localparam logic [1:0] SRC_UNDER   = 2'd2;
  localparam logic [1:0] SRC_OVER    = 2'd3;

  // What an item in flight turns into
  typedef enum logic [2:0] {
    KIND_WRITE,
    KIND_MASK,
    KIND_LOG,
    KIND_LIN,
    KIND_ZERO
  } cmpc_kind_t;

  typedef struct packed {
    logic                 action;
    logic [7:0]           palette_index;
    logic [23:0]          palette_rgb;
    logic signed [31:0]   intensity;
  } cmpc_in_t;

  typedef struct packed {
    logic [23:0] pixel_rgb;
    logic [1:0]  color_source;
  } cmpc_out_t;

  typedef struct packed {
    logic [3:0]         mode_bits;
    logic [23:0]        polygon_color;
    logic [23:0]        under_color;
    logic [23:0]        over_color;
    logic signed [31:0] lower_level;
    logic [31:0]        linear_gain;
    logic signed [23:0] log_lower;
    logic [31:0]        log_gain;
  } cmpc_cfg_t;

  // Pipeline payload; later stages fill the later fields
  typedef struct packed {
    cmpc_kind_t           kind;
    logic [1:0]           src;
    logic [PAL_IDX_W-1:0] pal_index;
    logic [RGB_W-1:0]     pal_rgb;     // write data, or the mask color
    logic signed [31:0]   x;
    logic signed [5:0]    lg_int;      // integer part of log2
    logic [31:0]          m;           // mantissa, Q1.31
    logic [15:0]          frac;        // log2 fraction bits
    logic [31:0]          d_mag;       // positive distance above the lower level
    logic [63:0]          prod;        // distance times gain
  } cmpc_work_t;

endpackage

>>> src/coded_mask_pixel_colormap_unit.sv
// Top level of the coded-mask pixel colormap unit: registers and pipeline.
//
//   channel  handshake                  payload
//   in       in_valid / in_ready        cmpc_in_t: action, palette_index, palette_rgb, intensity
//   out      out_valid / out_ready      cmpc_out_t: pixel_rgb, color_source
//   cfg      cfg_write_en (no wait)     cfg_index, cfg_data
//
// One item per cycle while the output is not stalled. An item passes from input transfer to
// result through the classify stage, the 16 registered mantissa squarings of the log2 unit,
// the distance and gain stages and the palette read register.
// Palette writes flow through the same pipeline and produce no result.
// rst is synchronous and clears the registers and all stage valids; the palette
// keeps whatever it holds. Each stage holds when the one after it is full and stalled.
module coded_mask_pixel_colormap_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cmpc_pkg::cmpc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cmpc_pkg::cmpc_out_t out_data,
  input  logic                cfg_write_en,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int NSQ = cmpc_pkg::LOG_SQUARINGS;

  cmpc_pkg::cmpc_cfg_t  cfg;
  logic                 sq_valid [NSQ+1];
  logic                 sq_ready [NSQ+1];
  cmpc_pkg::cmpc_work_t sq_work  [NSQ+1];
  logic                 sc_valid, sc_ready;
  cmpc_pkg::cmpc_work_t sc_work;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        cmpc_pkg::REG_MODE:        cfg.mode_bits     <= cfg_data[3:0];
        cmpc_pkg::REG_POLYGON:     cfg.polygon_color <= cfg_data[23:0];
        cmpc_pkg::REG_UNDER:       cfg.under_color   <= cfg_data[23:0];
        cmpc_pkg::REG_OVER:        cfg.over_color    <= cfg_data[23:0];
        cmpc_pkg::REG_LOWER_LEVEL: cfg.lower_level   <= cfg_data;
        cmpc_pkg::REG_LINEAR_GAIN: cfg.linear_gain   <= cfg_data;
        cmpc_pkg::REG_LOG_LOWER:   cfg.log_lower     <= cfg_data[23:0];
        cmpc_pkg::REG_LOG_GAIN:    cfg.log_gain      <= cfg_data;
      endcase
    end
  end

  // Classify stage
  cmpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (sq_valid[0]),
    .out_ready (sq_ready[0]),
    .out_work  (sq_work[0])
  );

  // log2 fraction chain, one bit per stage
  for (genvar i = 0; i < NSQ; i++) begin : g_sq
    cmpc_square u_square (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_valid[i]),
      .in_ready  (sq_ready[i]),
      .in_work   (sq_work[i]),
      .out_valid (sq_valid[i+1]),
      .out_ready (sq_ready[i+1]),
      .out_work  (sq_work[i+1])
    );
  end

  // Distance and gain
  cmpc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sq_valid[NSQ]),
    .in_ready  (sq_ready[NSQ]),
    .in_work   (sq_work[NSQ]),
    .out_valid (sc_valid),
    .out_ready (sc_ready),
    .out_work  (sc_work)
  );

  // Palette lookup and result register
  cmpc_palette u_palette (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sc_valid),
    .in_ready  (sc_ready),
    .in_work   (sc_work),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> src/cmpc_front.sv
// Input stage: classifies an item, picks mask colors and normalizes for log2.
module cmpc_front (
  input  logic                clk,
  input  logic                rst,
  input  cmpc_pkg::cmpc_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  cmpc_pkg::cmpc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cmpc_pkg::cmpc_work_t out_work
);

  cmpc_pkg::cmpc_work_t work_next;

  assign in_ready = !out_valid || out_ready;

  // Classify and find the leading one
  always_comb begin
    logic [31:0] ux;
    logic [4:0]  msb;
    ux  = in_data.intensity;
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (ux[i]) msb = 5'(i);
    end
    work_next           = '0;
    work_next.pal_index = in_data.palette_index;
    work_next.pal_rgb   = in_data.palette_rgb;
    work_next.x         = in_data.intensity;
    work_next.src       = cmpc_pkg::SRC_PALETTE;
    work_next.lg_int    = $signed({1'b0, msb}) - 6'(cmpc_pkg::FRAC_BITS);
    work_next.m         = ux << (5'd31 - msb);
    work_next.frac      = '0;
    if (in_data.action == cmpc_pkg::ACT_WRITE) begin
      work_next.kind = cmpc_pkg::KIND_WRITE;
    end else if (cfg.mode_bits[cmpc_pkg::MODE_POLY] &&
                 in_data.intensity == cmpc_pkg::CODE_POLYGON) begin
      work_next.kind    = cmpc_pkg::KIND_MASK;
      work_next.src     = cmpc_pkg::SRC_POLYGON;
      work_next.pal_rgb = cfg.polygon_color;
    end else if (cfg.mode_bits[cmpc_pkg::MODE_UNDER] &&
                 in_data.intensity == cmpc_pkg::CODE_UNDER) begin
      work_next.kind    = cmpc_pkg::KIND_MASK;
      work_next.src     = cmpc_pkg::SRC_UNDER;
      work_next.pal_rgb = cfg.under_color;
    end else if (cfg.mode_bits[cmpc_pkg::MODE_OVER] &&
                 in_data.intensity == cmpc_pkg::CODE_OVER) begin
      work_next.kind    = cmpc_pkg::KIND_MASK;
      work_next.src     = cmpc_pkg::SRC_OVER;
      work_next.pal_rgb = cfg.over_color;
    end else if (cfg.mode_bits[cmpc_pkg::MODE_LOG]) begin
      // below 1.0 the log index is zero
      if (in_data.intensity < cmpc_pkg::INT_ONE) begin
        work_next.kind = cmpc_pkg::KIND_ZERO;
      end else begin
        work_next.kind = cmpc_pkg::KIND_LOG;
      end
    end else begin
      work_next.kind = cmpc_pkg::KIND_LIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_work <= work_next;
    end
  end

endmodule

>>> src/cmpc_square.sv
// One log2 fraction step: square the mantissa and take one result bit.
module cmpc_square (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cmpc_pkg::cmpc_work_t in_work,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cmpc_pkg::cmpc_work_t out_work
);

  cmpc_pkg::cmpc_work_t work_next;
  logic [63:0]          sq;
  logic [32:0]          top_bits;

  assign in_ready = !out_valid || out_ready;

  // Square in Q1.31, truncate, renormalize when the value reaches 2.0
  assign sq       = 64'(in_work.m) * 64'(in_work.m);
  assign top_bits = sq[63:31];

  always_comb begin
    work_next = in_work;
    if (top_bits[32]) begin
      work_next.m    = top_bits[32:1];
      work_next.frac = {in_work.frac[14:0], 1'b1};
    end else begin
      work_next.m    = top_bits[31:0];
      work_next.frac = {in_work.frac[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_work <= work_next;
    end
  end

endmodule

>>> src/cmpc_scale.sv
// Scaling stages: distance above the lower level, then times the gain.
module cmpc_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  cmpc_pkg::cmpc_cfg_t  cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cmpc_pkg::cmpc_work_t in_work,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cmpc_pkg::cmpc_work_t out_work
);

  cmpc_pkg::cmpc_work_t diff_work, diff_next, mul_next;
  logic                 diff_valid, diff_ready;

  assign in_ready   = !diff_valid || diff_ready;
  assign diff_ready = !out_valid || out_ready;

  // Distance stage: a non-positive distance maps to index zero
  always_comb begin
    logic signed [21:0] lval;
    logic signed [32:0] d;
    lval      = $signed({in_work.lg_int, in_work.frac});
    diff_next = in_work;
    if (in_work.kind == cmpc_pkg::KIND_LOG) begin
      d = 33'(lval) - 33'(cfg.log_lower);
    end else begin
      d = 33'(in_work.x) - 33'(cfg.lower_level);
    end
    diff_next.d_mag = d[31:0];
    if ((in_work.kind == cmpc_pkg::KIND_LOG || in_work.kind == cmpc_pkg::KIND_LIN) &&
        (d[32] || d == '0)) begin
      diff_next.kind = cmpc_pkg::KIND_ZERO;
    end
  end

  // Gain stage
  always_comb begin
    logic [31:0] gain;
    gain = (diff_work.kind == cmpc_pkg::KIND_LOG) ? cfg.log_gain : cfg.linear_gain;
    mul_next      = diff_work;
    mul_next.prod = 64'(diff_work.d_mag) * 64'(gain);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) diff_valid <= in_valid;
      if (diff_ready) out_valid <= diff_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) diff_work <= diff_next;
    if (diff_valid && diff_ready) out_work <= mul_next;
  end

endmodule

>>> src/cmpc_palette.sv
// Palette memory with index saturation and the result register.
module cmpc_palette (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cmpc_pkg::cmpc_work_t in_work,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cmpc_pkg::cmpc_out_t  out_data
);

  logic [cmpc_pkg::RGB_W-1:0]     mem [cmpc_pkg::PALETTE_ENTRIES];
  logic [cmpc_pkg::RGB_W-1:0]     rd_q, color_q;
  logic [1:0]                     src_q;
  logic [cmpc_pkg::PAL_IDX_W-1:0] idx;
  logic                           take, is_write;
  logic                           hi_lin, hi_log;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign is_write = (in_work.kind == cmpc_pkg::KIND_WRITE);

  // Truncate and clamp the scaled product to a palette index
  assign hi_lin = |in_work.prod[63:cmpc_pkg::LIN_SHIFT+cmpc_pkg::PAL_IDX_W];
  assign hi_log = |in_work.prod[63:cmpc_pkg::LOG_SHIFT+cmpc_pkg::PAL_IDX_W];

  always_comb begin
    if (in_work.kind == cmpc_pkg::KIND_ZERO) begin
      idx = '0;
    end else if (in_work.kind == cmpc_pkg::KIND_LOG) begin
      idx = hi_log ? cmpc_pkg::INDEX_MAX
                   : in_work.prod[cmpc_pkg::LOG_SHIFT +: cmpc_pkg::PAL_IDX_W];
    end else begin
      idx = hi_lin ? cmpc_pkg::INDEX_MAX
                   : in_work.prod[cmpc_pkg::LIN_SHIFT +: cmpc_pkg::PAL_IDX_W];
    end
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (take && is_write) begin
      mem[in_work.pal_index] <= in_work.pal_rgb;
    end
  end

  // Memory read port and result payload
  always_ff @(posedge clk) begin
    if (take && !is_write) begin
      rd_q    <= mem[idx];
      color_q <= in_work.pal_rgb;
      src_q   <= (in_work.kind == cmpc_pkg::KIND_MASK) ? in_work.src
                                                       : cmpc_pkg::SRC_PALETTE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid && !is_write;
    end
  end

  assign out_data.pixel_rgb    = (src_q == cmpc_pkg::SRC_PALETTE) ? rd_q : color_q;
  assign out_data.color_source = src_q;

endmodule

>>> test/tb.sv
// Testbench for the coded-mask pixel colormap unit: directed and random pixel streams.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 30;      // pipeline is 20 deep; writes give no result
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS   = 105;

  typedef enum int {
    STYLE_LINEAR,
    STYLE_LOG,
    STYLE_RANDOM,
    STYLE_EXTREME
  } cfg_style_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  cmpc_pkg::cmpc_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  cmpc_pkg::cmpc_out_t out_data;
  logic                cfg_write_en;
  logic [2:0]          cfg_index;
  logic [31:0]         cfg_data;

  // Shadow of the block: registers, palette and the colors still owed
  cmpc_pkg::cmpc_cfg_t        regs_shadow;
  logic [cmpc_pkg::RGB_W-1:0] palette_shadow [cmpc_pkg::PALETTE_ENTRIES];
  bit                         palette_loaded [cmpc_pkg::PALETTE_ENTRIES];
  cmpc_pkg::cmpc_out_t        color_queue [$];

  int unsigned lin_span;
  bit          gaps_on;
  bit          stalls_on;
  int          errors = 0;
  int          cycles = 0;

  coded_mask_pixel_colormap_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // log2 of a positive raw intensity, Q8.16; fraction by repeated squaring
  function automatic int log2_q16(logic [31:0] raw);
    int          msb;
    int          frac;
    logic [63:0] m;
    msb = 0;
    for (int b = 0; b < 32; b++) begin
      if (raw[b]) msb = b;
    end
    m = (64'(raw) << (31 - msb)) & 64'hFFFF_FFFF;
    frac = 0;
    for (int i = 0; i < cmpc_pkg::LOG_SQUARINGS; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return (msb - cmpc_pkg::FRAC_BITS) * 65536 + frac;
  endfunction

  function automatic int scale_to_index(longint delta, logic [31:0] gain, int shift);
    logic [63:0] dm;
    logic [63:0] q;
    if (delta <= 0) return 0;
    dm = delta;
    q = (dm * 64'(gain)) >> shift;
    return (q > 64'd255) ? 255 : int'(q);
  endfunction

  function automatic int palette_index_of(logic signed [31:0] x);
    if (regs_shadow.mode_bits[cmpc_pkg::MODE_LOG]) begin
      if (x < cmpc_pkg::INT_ONE) return 0;
      return scale_to_index(longint'(log2_q16(x)) - longint'(regs_shadow.log_lower),
                            regs_shadow.log_gain, cmpc_pkg::LOG_SHIFT);
    end
    return scale_to_index(longint'(x) - longint'(regs_shadow.lower_level),
                          regs_shadow.linear_gain, cmpc_pkg::LIN_SHIFT);
  endfunction

  function automatic cmpc_pkg::cmpc_out_t predict_color(logic signed [31:0] x);
    cmpc_pkg::cmpc_out_t r;
    if (regs_shadow.mode_bits[cmpc_pkg::MODE_POLY] && x == cmpc_pkg::CODE_POLYGON) begin
      r.pixel_rgb    = regs_shadow.polygon_color;
      r.color_source = cmpc_pkg::SRC_POLYGON;
    end else if (regs_shadow.mode_bits[cmpc_pkg::MODE_UNDER] &&
                 x == cmpc_pkg::CODE_UNDER) begin
      r.pixel_rgb    = regs_shadow.under_color;
      r.color_source = cmpc_pkg::SRC_UNDER;
    end else if (regs_shadow.mode_bits[cmpc_pkg::MODE_OVER] &&
                 x == cmpc_pkg::CODE_OVER) begin
      r.pixel_rgb    = regs_shadow.over_color;
      r.color_source = cmpc_pkg::SRC_OVER;
    end else begin
      r.pixel_rgb    = palette_shadow[palette_index_of(x)];
      r.color_source = cmpc_pkg::SRC_PALETTE;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // One transfer on the input channel; the shadow is updated at acceptance
  task automatic send_item(input cmpc_pkg::cmpc_in_t item);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (item.action == cmpc_pkg::ACT_WRITE) begin
      palette_shadow[item.palette_index] = item.palette_rgb;
      palette_loaded[item.palette_index] = 1'b1;
    end else begin
      color_queue.push_back(predict_color(item.intensity));
    end
  endtask

  task automatic send_write(input logic [7:0] idx, input logic [23:0] rgb);
    cmpc_pkg::cmpc_in_t item;
    item.action        = cmpc_pkg::ACT_WRITE;
    item.palette_index = idx;
    item.palette_rgb   = rgb;
    item.intensity     = $urandom;
    send_item(item);
  endtask

  // A pixel; an entry it would read that was never loaded is loaded first
  task automatic send_pixel(input logic signed [31:0] x);
    cmpc_pkg::cmpc_in_t  item;
    cmpc_pkg::cmpc_out_t guess;
    int                  idx;
    guess = predict_color(x);
    if (guess.color_source == cmpc_pkg::SRC_PALETTE) begin
      idx = palette_index_of(x);
      if (!palette_loaded[idx]) send_write(8'(idx), 24'($urandom));
    end
    item.action        = cmpc_pkg::ACT_PIXEL;
    item.palette_index = 8'($urandom);
    item.palette_rgb   = 24'($urandom);
    item.intensity     = x;
    send_item(item);
  endtask

  // Stop sending, let all results arrive and the writes behind them settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (color_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(posedge clk);
  endtask

  // Unused upper data bits carry junk; the block must ignore them
  task automatic set_config(input cmpc_pkg::cmpc_cfg_t c);
    logic [31:0] junk;
    wait_idle();
    regs_shadow = c;
    junk = $urandom;
    write_reg(cmpc_pkg::REG_MODE, {junk[31:4], c.mode_bits});
    junk = $urandom;
    write_reg(cmpc_pkg::REG_POLYGON, {junk[31:24], c.polygon_color});
    junk = $urandom;
    write_reg(cmpc_pkg::REG_UNDER, {junk[31:24], c.under_color});
    junk = $urandom;
    write_reg(cmpc_pkg::REG_OVER, {junk[31:24], c.over_color});
    write_reg(cmpc_pkg::REG_LOWER_LEVEL, c.lower_level);
    write_reg(cmpc_pkg::REG_LINEAR_GAIN, c.linear_gain);
    junk = $urandom;
    write_reg(cmpc_pkg::REG_LOG_LOWER, {junk[31:24], c.log_lower});
    write_reg(cmpc_pkg::REG_LOG_GAIN, c.log_gain);
    cfg_write_en <= 1'b0;
  endtask

  // Settings; the usual ones spread intensities over the whole palette
  function automatic cmpc_pkg::cmpc_cfg_t rand_config(cfg_style_t style);
    cmpc_pkg::cmpc_cfg_t c;
    int unsigned         span;
    c.mode_bits     = 4'($urandom);
    c.polygon_color = 24'($urandom);
    c.under_color   = 24'($urandom);
    c.over_color    = 24'($urandom);
    c.lower_level   = $urandom;
    c.linear_gain   = $urandom;
    c.log_lower     = 24'($urandom);
    c.log_gain      = $urandom;
    lin_span        = 1 << 20;
    case (style)
      STYLE_LINEAR: begin
        c.mode_bits[cmpc_pkg::MODE_LOG] = 1'b0;
        span          = $urandom_range(256, 1 << 26);
        c.lower_level = int'($urandom_range(0, 1 << 29)) - (1 << 28);
        c.linear_gain = 32'((64'd255 << 32) / span);
        lin_span      = span;
      end
      STYLE_LOG: begin
        c.mode_bits[cmpc_pkg::MODE_LOG] = 1'b1;
        span        = $urandom_range(2 * 65536, 20 * 65536);
        c.log_lower = 24'(int'($urandom_range(0, 18 * 65536)) - 8 * 65536);
        c.log_gain  = 32'((64'd255 << 40) / span);
      end
      STYLE_EXTREME: begin
        if ($urandom_range(0, 1)) begin
          c.mode_bits   = 4'hF;
          c.polygon_color = 24'hFF_FFFF;
          c.under_color = 24'hFF_FFFF;
          c.over_color  = 24'hFF_FFFF;
          c.lower_level = 32'sh8000_0000;
          c.linear_gain = 32'hFFFF_FFFF;
          c.log_lower   = 24'sh80_0000;
          c.log_gain    = 32'hFFFF_FFFF;
        end else begin
          c.mode_bits   = 4'h0;
          c.polygon_color = 24'h00_0000;
          c.under_color = 24'h00_0000;
          c.over_color  = 24'h00_0000;
          c.lower_level = 32'sh7FFF_FFFF;
          c.linear_gain = 32'h0;
          c.log_lower   = 24'sh7F_FFFF;
          c.log_gain    = 32'h0;
        end
      end
      default: ;
    endcase
    return c;
  endfunction

  // Mix of codes, near codes, raw noise, small values near zero and values in and around the scaled range
  function automatic logic signed [31:0] rand_intensity();
    logic signed [31:0] v;
    logic signed [31:0] code;
    longint             t;
    int                 sel;
    int                 e;
    sel = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0: code = cmpc_pkg::CODE_POLYGON;
      1: code = cmpc_pkg::CODE_UNDER;
      default: code = cmpc_pkg::CODE_OVER;
    endcase
    if (sel < 12) begin
      v = code;
    end else if (sel < 20) begin
      v = code + int'($urandom_range(0, 2)) - 1;
    end else if (sel < 32) begin
      v = $urandom;
    end else if (sel < 40) begin
      v = int'($urandom_range(0, 600)) - 100;
    end else if (regs_shadow.mode_bits[cmpc_pkg::MODE_LOG]) begin
      e = $urandom_range(0, 30);
      v = (1 << e) | ($urandom & ((1 << e) - 1));
    end else begin
      t = longint'(regs_shadow.lower_level) + longint'($urandom_range(0, lin_span + lin_span / 4))
          - longint'(lin_span / 8);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      v = t[31:0];
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Receiver stalls in bursts
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Each output transfer against the oldest owed color
  always @(posedge clk) begin
    cmpc_pkg::cmpc_out_t owed;
    if (!rst && out_valid && out_ready) begin
      if (color_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual rgb %06h source %0d",
                 $time, out_data.pixel_rgb, out_data.color_source);
      end else begin
        owed = color_queue.pop_front();
        if (out_data.pixel_rgb !== owed.pixel_rgb) begin
          errors++;
          $display("%0t: pixel_rgb expected %06h actual %06h",
                   $time, owed.pixel_rgb, out_data.pixel_rgb);
        end
        if (out_data.color_source !== owed.color_source) begin
          errors++;
          $display("%0t: color_source expected %0d actual %0d",
                   $time, owed.color_source, out_data.color_source);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers straight out of reset: zero gain, masks off, so codes hit entry 0
  task automatic test_reset_defaults();
    send_pixel(32'sh7FFF_FFFF);
    send_pixel(32'sh8000_0000);
    send_pixel(cmpc_pkg::CODE_POLYGON);
    send_pixel(cmpc_pkg::CODE_OVER);
    send_pixel(32'sd0);
  endtask

  task automatic test_mask_codes();
    cmpc_pkg::cmpc_cfg_t c;
    c = rand_config(STYLE_LINEAR);
    c.mode_bits     = 4'b1110;
    c.polygon_color = 24'hFF_FFFF;
    c.under_color   = 24'h00_0000;
    c.over_color    = 24'hA5_5A3C;
    set_config(c);
    send_pixel(cmpc_pkg::CODE_POLYGON);
    send_pixel(cmpc_pkg::CODE_UNDER);
    send_pixel(cmpc_pkg::CODE_OVER);
    send_pixel(cmpc_pkg::CODE_POLYGON + 1);
    send_pixel(cmpc_pkg::CODE_OVER - 1);
    // only the code -3 mask on: the other codes go through the palette
    c.mode_bits = 4'b0100;
    set_config(c);
    send_pixel(cmpc_pkg::CODE_POLYGON);
    send_pixel(cmpc_pkg::CODE_UNDER);
    send_pixel(cmpc_pkg::CODE_OVER);
  endtask

  task automatic test_linear_extremes();
    cmpc_pkg::cmpc_cfg_t c;
    c = rand_config(STYLE_LINEAR);
    c.mode_bits   = 4'b0000;
    c.lower_level = 32'sh8000_0000;
    c.linear_gain = 32'hFFFF_FFFF;
    set_config(c);
    send_write(8'd0, 24'h00_0000);
    send_pixel(32'sh7FFF_FFFF);
    send_pixel(32'sh8000_0000);
    send_pixel(32'sh8000_0001);
    // write then read of the same entry, in that order
    send_write(8'd255, 24'hFF_FFFF);
    send_pixel(32'sd0);
    c.lower_level = 32'sh7FFF_FFFF;
    set_config(c);
    send_pixel(32'sh7FFF_FFFF);
    send_pixel(32'sh8000_0000);
  endtask

  task automatic test_log_scale();
    cmpc_pkg::cmpc_cfg_t c;
    c = rand_config(STYLE_LOG);
    c.mode_bits = 4'b1111;
    c.log_lower = 24'sh80_0000;
    c.log_gain  = 32'((64'd255 << 40) / (64'd128 * 65536));
    set_config(c);
    send_pixel(cmpc_pkg::INT_ONE - 1);
    send_pixel(cmpc_pkg::INT_ONE);
    send_pixel(32'sh7FFF_FFFF);
    send_pixel(32'sd0);
    send_pixel(cmpc_pkg::CODE_OVER);
    send_pixel(32'sh8000_0000);
    c.log_lower = 24'sh7F_FFFF;
    c.log_gain  = 32'hFFFF_FFFF;
    set_config(c);
    send_pixel(cmpc_pkg::INT_ONE);
    send_pixel(32'sh7FFF_FFFF);
  endtask

  // Phases of random traffic, each under new settings; the last runs flat out
  task automatic test_random_mix();
    int sel;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) set_config(rand_config(STYLE_LINEAR));
      else if (sel < 8) set_config(rand_config(STYLE_LOG));
      else if (sel < 9) set_config(rand_config(STYLE_RANDOM));
      else set_config(rand_config(STYLE_EXTREME));
      gaps_on   = (p < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      stalls_on = (p < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 15) send_write(8'($urandom), 24'($urandom));
        else send_pixel(rand_intensity());
      end
    end
  endtask

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    in_data      <= '0;
    cfg_write_en <= 1'b0;
    cfg_index    <= cmpc_pkg::REG_MODE;
    cfg_data     <= '0;
    regs_shadow  = '0;
    lin_span     = 1 << 20;
    gaps_on      = 1'b1;
    stalls_on    = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_mask_codes();
    test_linear_extremes();
    test_log_scale();
    test_random_mix();

    wait_idle();
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
